/* hdl/definite_time_overlimit_relay_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef DEFINITE_TIME_OVERLIMIT_RELAY_UNIT_DEFINES_SVH
`define DEFINITE_TIME_OVERLIMIT_RELAY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DTOR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dtor assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DTOR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> post) \
        else $error("dtor assertion failed");

`endif

/* hdl/dtor_pkg.sv */
package dtor_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COUNT_BITS  = 20;
    localparam int RATIO_BITS      = 16;
    localparam logic [RATIO_BITS-1:0] RATIO_ONE = 16'h8000;
    localparam int IDX_BITS        = 3;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_PICKUP_LEVEL     = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_DROPOUT_RATIO    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_DROPOUT_SAMPLES  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_COMM_ON_SAMPLES  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_COMM_OFF_SAMPLES = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_TRIP_SAMPLES     = 3'd5;

    // State flags of the relay element
    typedef struct packed {
        logic pickup;
        logic hold;
        logic comm;
        logic trip;
        logic latch;
    } flags_t;

    // One result item
    typedef struct packed {
        logic active;
        logic raw_pickup;
        logic held_pickup;
        logic comm_pickup;
        logic trip_out;
        logic trip_latched;
    } result_t;

    function automatic int max_bits(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* hdl/dtor_cfg.sv */
module dtor_cfg #(
    parameter int SAMPLE_BITS = dtor_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = dtor_pkg::DEF_COUNT_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [dtor_pkg::IDX_BITS-1:0]               cfg_index,
    input  logic [dtor_pkg::max_bits(dtor_pkg::max_bits(SAMPLE_BITS, COUNT_BITS),
                                     dtor_pkg::RATIO_BITS)-1:0] cfg_data,
    input  dtor_pkg::flags_t                            flags,
    output logic [SAMPLE_BITS-1:0]                      pickup_level,
    output logic [dtor_pkg::RATIO_BITS-1:0]             drop_ratio,
    output logic [COUNT_BITS-1:0]                       dropout_samples,
    output logic [COUNT_BITS-1:0]                       comm_on_samples,
    output logic [COUNT_BITS-1:0]                       comm_off_samples,
    output logic [COUNT_BITS-1:0]                       trip_samples,
    output logic                                        active
);
    import dtor_pkg::*;

    logic [SAMPLE_BITS-1:0] level_reg, level_next;
    logic [RATIO_BITS-1:0]  ratio_reg, ratio_next;
    logic [COUNT_BITS-1:0]  drop_reg, drop_next;
    logic [COUNT_BITS-1:0]  con_reg, con_next;
    logic [COUNT_BITS-1:0]  coff_reg, coff_next;
    logic [COUNT_BITS-1:0]  trip_reg, trip_next;
    logic                   active_reg, active_next;
    logic                   known_idx;
    logic                   cfg_ok;

    // Register write decode
    always_comb
    begin
        level_next = level_reg;
        ratio_next = ratio_reg;
        drop_next  = drop_reg;
        con_next   = con_reg;
        coff_next  = coff_reg;
        trip_next  = trip_reg;
        known_idx  = 1'b1;
        unique case (cfg_index)
            REG_PICKUP_LEVEL:     level_next = cfg_data[SAMPLE_BITS-1:0];
            REG_DROPOUT_RATIO:    ratio_next = cfg_data[RATIO_BITS-1:0];
            REG_DROPOUT_SAMPLES:  drop_next  = cfg_data[COUNT_BITS-1:0];
            REG_COMM_ON_SAMPLES:  con_next   = cfg_data[COUNT_BITS-1:0];
            REG_COMM_OFF_SAMPLES: coff_next  = cfg_data[COUNT_BITS-1:0];
            REG_TRIP_SAMPLES:     trip_next  = cfg_data[COUNT_BITS-1:0];
            default:              known_idx  = 1'b0;
        endcase
    end

    // Settings check on the values after the write
    assign cfg_ok = (level_next != '0) && (trip_next != '0) &&
                    (ratio_next != '0) && (ratio_next <= RATIO_ONE) &&
                    (drop_next <= trip_next) &&
                    (con_next != '0) && (con_next <= trip_next) &&
                    (coff_next != '0);

    // Active is re-evaluated only on a write to a known register
    always_comb
    begin
        active_next = active_reg;
        if (cfg_we && known_idx)
        begin
            active_next = cfg_ok && !flags.pickup && !flags.hold &&
                          !flags.trip && !flags.latch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            ratio_reg  <= RATIO_ONE;
            drop_reg   <= '0;
            con_reg    <= '0;
            coff_reg   <= '0;
            trip_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                level_reg <= level_next;
                ratio_reg <= ratio_next;
                drop_reg  <= drop_next;
                con_reg   <= con_next;
                coff_reg  <= coff_next;
                trip_reg  <= trip_next;
            end
            active_reg <= active_next;
        end
    end

    assign pickup_level     = level_reg;
    assign drop_ratio       = ratio_reg;
    assign dropout_samples  = drop_reg;
    assign comm_on_samples  = con_reg;
    assign comm_off_samples = coff_reg;
    assign trip_samples     = trip_reg;
    assign active           = active_reg;

endmodule

/* hdl/dtor_core.sv */
module dtor_core #(
    parameter int SAMPLE_BITS = dtor_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = dtor_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [SAMPLE_BITS-1:0]          rms_value,
    input  logic                            inhibit,
    input  logic                            latch_reset,
    input  logic [SAMPLE_BITS-1:0]          pickup_level,
    input  logic [dtor_pkg::RATIO_BITS-1:0] drop_ratio,
    input  logic [COUNT_BITS-1:0]           dropout_samples,
    input  logic [COUNT_BITS-1:0]           comm_on_samples,
    input  logic [COUNT_BITS-1:0]           comm_off_samples,
    input  logic [COUNT_BITS-1:0]           trip_samples,
    input  logic                            active,
    output dtor_pkg::flags_t                flags,
    output dtor_pkg::result_t               result
);
    import dtor_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + RATIO_BITS;

    flags_t                flags_reg, flags_next;
    logic [COUNT_BITS-1:0] hold_cnt_reg, hold_cnt_next;
    logic [COUNT_BITS-1:0] comm_cnt_reg, comm_cnt_next;
    logic [COUNT_BITS-1:0] trip_cnt_reg, trip_cnt_next;
    logic [PROD_BITS-1:0]  scaled_rms;
    logic [PROD_BITS-1:0]  drop_level;
    logic                  below_drop;

    // Dropout threshold: rms * 1.0 (Q1.15) against level * ratio
    assign scaled_rms = {1'b0, rms_value, {(RATIO_BITS-1){1'b0}}};
    assign drop_level = {{RATIO_BITS{1'b0}}, pickup_level} *
                        {{SAMPLE_BITS{1'b0}}, drop_ratio};
    assign below_drop = scaled_rms < drop_level;

    // Next state of the relay element
    always_comb
    begin
        logic [COUNT_BITS-1:0] lim;
        logic [COUNT_BITS-1:0] cc;
        logic [COUNT_BITS-1:0] tc;

        flags_next    = flags_reg;
        hold_cnt_next = hold_cnt_reg;
        comm_cnt_next = comm_cnt_reg;
        trip_cnt_next = trip_cnt_reg;
        lim           = flags_reg.comm ? comm_off_samples : comm_on_samples;
        cc            = comm_cnt_reg;
        tc            = trip_cnt_reg;

        // hysteresis comparator, inhibit dominates
        if (rms_value > pickup_level)
            flags_next.pickup = 1'b1;
        if (below_drop || inhibit)
            flags_next.pickup = 1'b0;

        // dropout off-delay
        if (flags_next.pickup)
        begin
            hold_cnt_next   = '0;
            flags_next.hold = 1'b1;
        end
        else if (flags_reg.hold)
        begin
            if (hold_cnt_reg >= dropout_samples)
            begin
                flags_next.hold = 1'b0;
                hold_cnt_next   = '0;
            end
            else
                hold_cnt_next = hold_cnt_reg + 1'b1;
        end

        // comm on/off qualification
        if (flags_next.hold != flags_reg.comm)
        begin
            if (cc < lim)
                cc = cc + 1'b1;
            if (cc >= lim)
            begin
                flags_next.comm = flags_next.hold;
                comm_cnt_next   = '0;
            end
            else
                comm_cnt_next = cc;
        end
        else
            comm_cnt_next = '0;

        // trip on-delay
        if (flags_next.hold)
        begin
            if (tc < trip_samples)
                tc = tc + 1'b1;
            trip_cnt_next   = tc;
            flags_next.trip = tc >= trip_samples;
        end
        else
        begin
            trip_cnt_next   = '0;
            flags_next.trip = 1'b0;
        end

        // trip latch: set first, then qualified reset
        if (flags_next.trip)
            flags_next.latch = 1'b1;
        if (!flags_next.pickup && latch_reset)
            flags_next.latch = 1'b0;

        // inactive element keeps its state
        if (!active)
        begin
            flags_next    = flags_reg;
            hold_cnt_next = hold_cnt_reg;
            comm_cnt_next = comm_cnt_reg;
            trip_cnt_next = trip_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            hold_cnt_reg <= '0;
            comm_cnt_reg <= '0;
            trip_cnt_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg    <= flags_next;
            hold_cnt_reg <= hold_cnt_next;
            comm_cnt_reg <= comm_cnt_next;
            trip_cnt_reg <= trip_cnt_next;
        end
    end

    assign flags = flags_reg;

    // Result item for the sample now passing through
    always_comb
    begin
        result.active       = active;
        result.raw_pickup   = flags_next.pickup;
        result.held_pickup  = flags_next.hold;
        result.comm_pickup  = flags_next.comm;
        result.trip_out     = flags_next.trip;
        result.trip_latched = flags_next.latch;
    end

endmodule

/* hdl/definite_time_overlimit_relay_unit.sv */
// Definite-time over-limit relay element.
// Path: an accepted sample passes the input stage, then the result register, to its result item.
// Throughput: one sample per cycle while the result is not stalled; the state counters update in the same pass.
// Reset (rst_n, async low): registers to defaults, all flags and counters clear,
// element inactive until a valid set of registers is written.
module definite_time_overlimit_relay_unit #(
    parameter int SAMPLE_BITS = dtor_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = dtor_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dtor_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [dtor_pkg::max_bits(dtor_pkg::max_bits(SAMPLE_BITS, COUNT_BITS),
                                     dtor_pkg::RATIO_BITS)-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [SAMPLE_BITS-1:0]         rms_value,
    input  logic                           inhibit,
    input  logic                           latch_reset,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           active,
    output logic                           raw_pickup,
    output logic                           held_pickup,
    output logic                           comm_pickup,
    output logic                           trip_out,
    output logic                           trip_latched
);
    import dtor_pkg::*;

    logic                   stage_valid_reg;
    logic [SAMPLE_BITS-1:0] stage_rms_reg;
    logic                   stage_inh_reg;
    logic                   stage_rst_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    logic                   advance;
    logic                   accept;

    logic [SAMPLE_BITS-1:0] pickup_level;
    logic [RATIO_BITS-1:0]  drop_ratio;
    logic [COUNT_BITS-1:0]  dropout_samples;
    logic [COUNT_BITS-1:0]  comm_on_samples;
    logic [COUNT_BITS-1:0]  comm_off_samples;
    logic [COUNT_BITS-1:0]  trip_samples;
    logic                   cfg_active;
    flags_t                 flags;
    result_t                result;

    // Handshake: stage moves on when the result register is free or being taken
    assign advance  = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    dtor_cfg #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .flags           (flags),
        .pickup_level    (pickup_level),
        .drop_ratio      (drop_ratio),
        .dropout_samples (dropout_samples),
        .comm_on_samples (comm_on_samples),
        .comm_off_samples(comm_off_samples),
        .trip_samples    (trip_samples),
        .active          (cfg_active)
    );

    dtor_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rms_value       (stage_rms_reg),
        .inhibit         (stage_inh_reg),
        .latch_reset     (stage_rst_reg),
        .pickup_level    (pickup_level),
        .drop_ratio      (drop_ratio),
        .dropout_samples (dropout_samples),
        .comm_on_samples (comm_on_samples),
        .comm_off_samples(comm_off_samples),
        .trip_samples    (trip_samples),
        .active          (cfg_active),
        .flags           (flags),
        .result          (result)
    );

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (advance)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_rms_reg <= rms_value;
            stage_inh_reg <= inhibit;
            stage_rst_reg <= latch_reset;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign active       = out_reg.active;
    assign raw_pickup   = out_reg.raw_pickup;
    assign held_pickup  = out_reg.held_pickup;
    assign comm_pickup  = out_reg.comm_pickup;
    assign trip_out     = out_reg.trip_out;
    assign trip_latched = out_reg.trip_latched;

endmodule

/* hdl/dtor_checker.sv */
`include "definite_time_overlimit_relay_unit_defines.svh"

module dtor_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic raw_pickup,
    input logic held_pickup,
    input logic trip_out,
    input logic trip_latched
);

    // a stalled result item stays put
    `DTOR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(trip_latched))

    // the input side only backs up behind a stalled result
    `DTOR_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // out_valid follows every accepted sample
    `DTOR_ASSERT_NEXT(a_in_to_out, in_valid && !in_stall, ##1 out_valid)

    // trip and raw pickup both imply the held pickup
    `DTOR_ASSERT_NOW(a_trip_held, out_valid && (trip_out || raw_pickup), held_pickup)

endmodule

bind definite_time_overlimit_relay_unit dtor_checker u_dtor_checker (.*);
